[rtl/iida_pkg.sv]
// shared constants and control types for the indexed insert/delete array
package iida_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   localparam int ACTION_W   = 2;
   localparam int POSITION_W = 7;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int FILL_W     = 8;

   localparam logic [ACTION_W-1:0] ACTION_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic                load;
      logic                init_ptr_ins;
      logic                init_ptr_del;
      logic                rd_en;
      logic                rd_pos;
      logic                rd_below;
      logic                wr_shift;
      logic                wr_value;
      logic                ptr_dec;
      logic                ptr_inc;
      logic                count_inc;
      logic                count_dec;
      logic                finish;
      logic [STATUS_W-1:0] fin_status;
      logic                capture_read;
   } cmd_type;

   typedef struct packed {
      logic                is_insert;
      logic                is_delete;
      logic                fail;
      logic [STATUS_W-1:0] fail_code;
      logic                ins_first_last;
      logic                del_first_last;
      logic                ins_next_last;
      logic                del_next_last;
   } sts_type;

endpackage

[rtl/iida_req_if.sv]
// request channel: action, position and value with valid/ready
interface iida_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [iida_pkg::ACTION_W-1:0]        action;
   logic [iida_pkg::POSITION_W-1:0]      position;
   logic signed [iida_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output action, output position, output value, input ready);
   modport sink (input valid, input action, input position, input value, output ready);
endinterface

[rtl/iida_rsp_if.sv]
// response channel: status, fill count and read value with valid/ready
interface iida_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [iida_pkg::STATUS_W-1:0]        status;
   logic [iida_pkg::FILL_W-1:0]          fill_count;
   logic signed [iida_pkg::VALUE_W-1:0]  read_value;

   modport source (output valid, output status, output fill_count, output read_value,
                   input ready);
   modport sink (input valid, input status, input fill_count, input read_value,
                 output ready);
endinterface

[rtl/iida_ram.sv]
// generic single write port, single read port ram with registered read
module iida_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/iida_ctrl.sv]
// controller state machine sequencing checks, entry shifts and the response
module iida_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              rsp_ready,
   input  iida_pkg::sts_type sts,
   output iida_pkg::cmd_type cmd,
   output logic              req_ready,
   output logic              rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_INS_RD,
      ST_INS_WR,
      ST_INS_LAST,
      ST_DEL_RD,
      ST_DEL_WR,
      ST_DEL_LAST,
      ST_RD_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.fail) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = sts.fail_code;
               state_in       = ST_RESP;
            end else if (sts.is_insert) begin
               cmd.init_ptr_ins = 1'b1;
               state_in         = sts.ins_first_last ? ST_INS_LAST : ST_INS_RD;
            end else if (sts.is_delete) begin
               cmd.init_ptr_del = 1'b1;
               state_in         = sts.del_first_last ? ST_DEL_LAST : ST_DEL_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_pos = 1'b1;
               state_in   = ST_RD_WAIT;
            end
         end
         ST_INS_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_below = 1'b1;
            state_in     = ST_INS_WR;
         end
         ST_INS_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_dec  = 1'b1;
            state_in     = sts.ins_next_last ? ST_INS_LAST : ST_INS_RD;
         end
         ST_INS_LAST: begin
            cmd.wr_value   = 1'b1;
            cmd.count_inc  = 1'b1;
            cmd.finish     = 1'b1;
            cmd.fin_status = iida_pkg::STATUS_DONE;
            state_in       = ST_RESP;
         end
         ST_DEL_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DEL_WR;
         end
         ST_DEL_WR: begin
            cmd.wr_shift = 1'b1;
            cmd.ptr_inc  = 1'b1;
            state_in     = sts.del_next_last ? ST_DEL_LAST : ST_DEL_RD;
         end
         ST_DEL_LAST: begin
            cmd.count_dec  = 1'b1;
            cmd.finish     = 1'b1;
            cmd.fin_status = iida_pkg::STATUS_DONE;
            state_in       = ST_RESP;
         end
         ST_RD_WAIT: begin
            cmd.capture_read = 1'b1;
            cmd.finish       = 1'b1;
            cmd.fin_status   = iida_pkg::STATUS_DONE;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready && rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
         rsp_valid_ff <= (state_in == ST_RESP);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/iida_datapath.sv]
// datapath: request latch, fill count, shift pointer, entry ram and result registers
module iida_datapath #(
   parameter int CAPACITY = iida_pkg::CAPACITY_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  iida_pkg::cmd_type                     cmd,
   output iida_pkg::sts_type                     sts,
   input  logic [iida_pkg::ACTION_W-1:0]         req_action,
   input  logic [iida_pkg::POSITION_W-1:0]       req_position,
   input  logic signed [iida_pkg::VALUE_W-1:0]   req_value,
   output logic [iida_pkg::STATUS_W-1:0]         rsp_status,
   output logic [iida_pkg::FILL_W-1:0]           rsp_fill_count,
   output logic signed [iida_pkg::VALUE_W-1:0]   rsp_read_value
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int XW = ((iida_pkg::POSITION_W > CW) ? iida_pkg::POSITION_W : CW) + 2;

   logic [iida_pkg::ACTION_W-1:0]   action_ff;
   logic [iida_pkg::POSITION_W-1:0] pos_ff;
   logic [iida_pkg::VALUE_W-1:0]    value_ff;
   logic [CW-1:0]                   count_ff, count_in;
   logic [AW-1:0]                   ptr_ff;
   logic [iida_pkg::STATUS_W-1:0]   status_ff;
   logic [iida_pkg::VALUE_W-1:0]    read_value_ff;

   logic [XW-1:0]                   pos_x, cnt_x, ptr_x;
   logic                            full;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [iida_pkg::VALUE_W-1:0]    wr_data;
   logic [AW-1:0]                   rd_addr;
   logic [iida_pkg::VALUE_W-1:0]    rd_data;

   // widened copies so comparisons never wrap
   assign pos_x = XW'(pos_ff);
   assign cnt_x = XW'(count_ff);
   assign ptr_x = XW'(ptr_ff);
   assign full  = (count_ff == CW'(CAPACITY));

   always_comb begin
      sts           = '0;
      sts.is_insert = (action_ff == iida_pkg::ACTION_INSERT);
      sts.is_delete = (action_ff == iida_pkg::ACTION_DELETE);
      sts.fail_code = iida_pkg::STATUS_RANGE;
      if (action_ff == iida_pkg::ACTION_INSERT) begin
         if (full) begin
            sts.fail      = 1'b1;
            sts.fail_code = iida_pkg::STATUS_FULL;
         end else if (pos_x > cnt_x) begin
            sts.fail = 1'b1;
         end
      end else if (action_ff == iida_pkg::ACTION_DELETE ||
                   action_ff == iida_pkg::ACTION_READ) begin
         sts.fail = (pos_x >= cnt_x);
      end else begin
         sts.fail = 1'b1;
      end
      sts.ins_first_last = (pos_x == cnt_x);
      sts.del_first_last = (pos_x + XW'(1) >= cnt_x);
      sts.ins_next_last  = (ptr_x == pos_x + XW'(1));
      sts.del_next_last  = (ptr_x + XW'(2) >= cnt_x);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         pos_ff    <= req_position;
         value_ff  <= req_value;
      end
      if (cmd.init_ptr_ins) begin
         ptr_ff <= AW'(count_ff);
      end else if (cmd.init_ptr_del) begin
         ptr_ff <= AW'(pos_ff);
      end else if (cmd.ptr_dec) begin
         ptr_ff <= ptr_ff - AW'(1);
      end else if (cmd.ptr_inc) begin
         ptr_ff <= ptr_ff + AW'(1);
      end
      if (cmd.finish) begin
         status_ff     <= cmd.fin_status;
         read_value_ff <= cmd.capture_read ? rd_data : '0;
      end
   end

   always_comb begin
      if (cmd.rd_pos) begin
         rd_addr = AW'(pos_ff);
      end else if (cmd.rd_below) begin
         rd_addr = ptr_ff - AW'(1);
      end else begin
         rd_addr = ptr_ff + AW'(1);
      end
   end

   assign wr_en   = cmd.wr_shift | cmd.wr_value;
   assign wr_addr = ptr_ff;
   assign wr_data = cmd.wr_value ? value_ff : rd_data;

   iida_ram #(
      .WIDTH (iida_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_status     = status_ff;
   assign rsp_fill_count = iida_pkg::FILL_W'(count_ff);
   assign rsp_read_value = read_value_ff;

endmodule

[rtl/indexed_insert_delete_array.sv]
// top level of the indexed insert/delete array
//
//   channel    dir   handshake        payload
//   req_chan   in    valid / ready    action, position, value
//   rsp_chan   out   valid / ready    status, fill_count, read_value
//
// one item at a time; req_chan.ready is high only while no item is in flight
// read: check, then a read wait state, then the response; errors: check, then the response
// insert moves count - position entries, delete moves count - position - 1
// each moved entry costs a read then a write on the single entry ram port pair
// synchronous reset empties the array; a stalled response holds until taken
module indexed_insert_delete_array #(
   parameter int CAPACITY = iida_pkg::CAPACITY_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   iida_req_if.sink          req_chan,
   iida_rsp_if.source        rsp_chan
);

   iida_pkg::cmd_type cmd;
   iida_pkg::sts_type sts;

   iida_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid)
   );

   iida_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_chan.action),
      .req_position   (req_chan.position),
      .req_value      (req_chan.value),
      .rsp_status     (rsp_chan.status),
      .rsp_fill_count (rsp_chan.fill_count),
      .rsp_read_value (rsp_chan.read_value)
   );

endmodule

[rtl/iida_checker.sv]
// port-level assertions for the indexed insert/delete array and their bind
module iida_checker (
   input  logic       clock,
   input  logic       reset,
   iida_req_if.sink   req_chan,
   iida_rsp_if.source rsp_chan
);

   // no response pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   // a new request is never taken while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request ready while response pending");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.status) &&
         $stable(rsp_chan.fill_count) && $stable(rsp_chan.read_value))
      else $error("stalled response changed");

   // failed actions return zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status != iida_pkg::STATUS_DONE |->
         rsp_chan.read_value == '0)
      else $error("nonzero read value on failed action");

   // request ready is dropped after each request transfer
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request ready right after a transfer");

endmodule

bind indexed_insert_delete_array iida_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

[tb/testbench.sv]
// self-checking testbench for the indexed insert/delete array
`timescale 1ns / 100ps

module testbench;

   localparam int CAPACITY = iida_pkg::CAPACITY_DEFAULT;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 2 * CAPACITY + 40;
   localparam logic [iida_pkg::ACTION_W-1:0] ACTION_UNUSED = 2'd3;

   typedef struct {
      logic [iida_pkg::STATUS_W-1:0]       status;
      logic [iida_pkg::FILL_W-1:0]         fill_count;
      logic signed [iida_pkg::VALUE_W-1:0] read_value;
   } array_result_type;

   class array_scoreboard;
      logic signed [iida_pkg::VALUE_W-1:0] words [CAPACITY];
      int unsigned                         fill;
      array_result_type                    expected_q[$];
      int unsigned                         mismatches;
      int unsigned                         n_requests;
      int unsigned                         n_results;
      int unsigned                         n_full;
      int unsigned                         n_range;

      function new();
         fill = 0;
         mismatches = 0;
         n_requests = 0;
         n_results = 0;
         n_full = 0;
         n_range = 0;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch at %0t: %s", $time, msg);
      endfunction

      function void note_request(logic [iida_pkg::ACTION_W-1:0] act,
                                 logic [iida_pkg::POSITION_W-1:0] pos,
                                 logic signed [iida_pkg::VALUE_W-1:0] val);
         array_result_type exp_item;
         int unsigned      i;
         exp_item.status = iida_pkg::STATUS_DONE;
         exp_item.read_value = '0;
         case (act)
            iida_pkg::ACTION_INSERT: begin
               if (fill >= CAPACITY) begin
                  exp_item.status = iida_pkg::STATUS_FULL;
               end else if (pos > fill) begin
                  exp_item.status = iida_pkg::STATUS_RANGE;
               end else begin
                  for (i = fill; i > pos; i--) words[i] = words[i-1];
                  words[pos] = val;
                  fill++;
               end
            end
            iida_pkg::ACTION_DELETE: begin
               if (pos >= fill) begin
                  exp_item.status = iida_pkg::STATUS_RANGE;
               end else begin
                  for (i = pos; i + 1 < fill; i++) words[i] = words[i+1];
                  fill--;
               end
            end
            iida_pkg::ACTION_READ: begin
               if (pos >= fill) exp_item.status = iida_pkg::STATUS_RANGE;
               else exp_item.read_value = words[pos];
            end
            default: exp_item.status = iida_pkg::STATUS_RANGE;
         endcase
         if (exp_item.status == iida_pkg::STATUS_FULL) n_full++;
         if (exp_item.status == iida_pkg::STATUS_RANGE) n_range++;
         exp_item.fill_count = iida_pkg::FILL_W'(fill);
         expected_q.push_back(exp_item);
         n_requests++;
      endfunction

      function void check_response(logic [iida_pkg::STATUS_W-1:0] status,
                                   logic [iida_pkg::FILL_W-1:0] fill_count,
                                   logic signed [iida_pkg::VALUE_W-1:0] read_value);
         array_result_type exp_item;
         n_results++;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result status %0d fill %0d value %0d",
                             status, fill_count, read_value));
         end else begin
            exp_item = expected_q.pop_front();
            if (status !== exp_item.status)
               report($sformatf("status expected %0d got %0d", exp_item.status, status));
            if (fill_count !== exp_item.fill_count)
               report($sformatf("fill_count expected %0d got %0d",
                                exp_item.fill_count, fill_count));
            if (read_value !== exp_item.read_value)
               report($sformatf("read_value expected %0d got %0d",
                                exp_item.read_value, read_value));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic idle_on;
   logic hold_rsp;
   int unsigned stall_cycles;
   array_scoreboard sb;

   iida_req_if req_bus ();
   iida_rsp_if rsp_bus ();

   indexed_insert_delete_array #(.CAPACITY(CAPACITY)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic send_item(logic [iida_pkg::ACTION_W-1:0] act,
                            logic [iida_pkg::POSITION_W-1:0] pos,
                            logic signed [iida_pkg::VALUE_W-1:0] val);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.position <= pos;
      req_bus.value    <= val;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(act, pos, val);
   endtask

   task automatic send_random(int unsigned ins_w, int unsigned del_w);
      int unsigned                         r;
      int unsigned                         fill;
      logic [iida_pkg::ACTION_W-1:0]       act;
      logic [iida_pkg::POSITION_W-1:0]     pos;
      logic signed [iida_pkg::VALUE_W-1:0] val;
      r = $urandom_range(0, 99);
      fill = sb.fill;
      val = $urandom;
      if ($urandom_range(0, 15) == 0) val = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      if (r < 5) begin
         act = iida_pkg::ACTION_W'($urandom);
         pos = iida_pkg::POSITION_W'($urandom);
      end else if (r < 5 + ins_w) begin
         act = iida_pkg::ACTION_INSERT;
         if (fill < CAPACITY && $urandom_range(0, 9) != 0)
            pos = iida_pkg::POSITION_W'($urandom_range(0, fill));
         else pos = iida_pkg::POSITION_W'($urandom);
      end else begin
         act = (r < 5 + ins_w + del_w) ? iida_pkg::ACTION_DELETE : iida_pkg::ACTION_READ;
         if (fill > 0 && $urandom_range(0, 9) != 0)
            pos = iida_pkg::POSITION_W'($urandom_range(0, fill - 1));
         else pos = iida_pkg::POSITION_W'($urandom);
      end
      send_item(act, pos, val);
   endtask

   // hold the sender until every outstanding result has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   task automatic run_phase(int unsigned n_items, int unsigned ins_w, int unsigned del_w,
                            logic with_idle, int hold_at);
      int unsigned k;
      idle_on = with_idle;
      for (k = 0; k < n_items; k++) begin
         if (int'(k) == hold_at) hold_rsp = 1'b1;
         send_random(ins_w, del_w);
      end
      wait_drained();
   endtask

   // response side
   initial begin
      int unsigned w;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            w = LONG_HOLD_CYCLES;
         end else begin
            w = idle_on ? $urandom_range(0, 5) : 0;
         end
         if (w > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         sb.check_response(rsp_bus.status, rsp_bus.fill_count, rsp_bus.read_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", stall_cycles);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      idle_on = 1'b1;
      hold_rsp = 1'b0;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.action   <= iida_pkg::ACTION_INSERT;
      req_bus.position <= '0;
      req_bus.value    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty array rejections and the unused action code
      send_item(iida_pkg::ACTION_READ, 7'd0, $urandom);
      send_item(iida_pkg::ACTION_DELETE, 7'd0, $urandom);
      send_item(iida_pkg::ACTION_INSERT, 7'd1, $urandom);
      send_item(ACTION_UNUSED, 7'd0, $urandom);
      // front inserts, append, middle insert
      send_item(iida_pkg::ACTION_INSERT, 7'd0, 32'h7fffffff);
      send_item(iida_pkg::ACTION_INSERT, 7'd0, 32'h80000000);
      send_item(iida_pkg::ACTION_INSERT, 7'd2, 32'h00000000);
      send_item(iida_pkg::ACTION_INSERT, 7'd1, 32'hffffffff);
      send_item(iida_pkg::ACTION_READ, 7'd0, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd1, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd2, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd3, $urandom);
      // positions at and past the end
      send_item(iida_pkg::ACTION_READ, 7'd4, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd127, $urandom);
      send_item(iida_pkg::ACTION_INSERT, 7'd127, $urandom);
      send_item(iida_pkg::ACTION_DELETE, 7'd4, $urandom);
      send_item(ACTION_UNUSED, 7'd127, $urandom);
      // middle and last deletes, then empty again
      send_item(iida_pkg::ACTION_DELETE, 7'd1, $urandom);
      send_item(iida_pkg::ACTION_DELETE, 7'd2, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd0, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd1, $urandom);
      send_item(iida_pkg::ACTION_DELETE, 7'd0, $urandom);
      send_item(iida_pkg::ACTION_DELETE, 7'd0, $urandom);
      send_item(iida_pkg::ACTION_READ, 7'd0, $urandom);
      wait_drained();

      run_phase(100, 50, 25, 1'b1, -1);
      run_phase(170, 90, 3, 1'b1, 20);
      run_phase(100, 45, 30, 1'b0, -1);
      run_phase(140, 10, 75, 1'b1, -1);
      run_phase(170, 90, 3, 1'b0, -1);
      run_phase(100, 45, 30, 1'b1, 50);
      run_phase(50, 10, 75, 1'b1, -1);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
      end
      $display("run covered %0d requests and %0d results, including %0d full", sb.n_requests,
               sb.n_results, sb.n_full);
      $display("and %0d out of range rejections; %0d mismatches", sb.n_range, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/iida_pkg.sv
rtl/iida_req_if.sv
rtl/iida_rsp_if.sv
rtl/iida_ram.sv
rtl/iida_ctrl.sv
rtl/iida_datapath.sv
rtl/indexed_insert_delete_array.sv
rtl/iida_checker.sv
tb/testbench.sv
